### hw/rtl/mm2_pkg.sv
`timescale 1ns / 1ps

package mm2_pkg;

    localparam logic [31:0] MIX_MULT    = 32'h5bd1e995;
    localparam int          WORD_SHIFT  = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'd97;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE = 4'd0;
    localparam step_t STEP_MIX1 = 4'd1;
    localparam step_t STEP_MIX2 = 4'd2;
    localparam step_t STEP_MIX3 = 4'd3;
    localparam step_t STEP_MIX4 = 4'd4;
    localparam step_t STEP_MIX5 = 4'd5;
    localparam step_t STEP_TAIL1 = 4'd6;
    localparam step_t STEP_TAIL2 = 4'd7;
    localparam step_t STEP_TAIL3 = 4'd8;
    localparam step_t STEP_FIN1 = 4'd9;
    localparam step_t STEP_FIN2 = 4'd10;
    localparam step_t STEP_FIN3 = 4'd11;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_K,
        MUL_H
    } mul_sel_t;

    typedef enum logic [1:0] {
        K_NONE,
        K_LOAD_P,
        K_P_XS24
    } k_op_t;

    typedef enum logic [2:0] {
        H_NONE,
        H_LOAD_P,
        H_XOR_GATHER,
        H_XS13,
        H_P_XOR_K,
        H_P_XS15
    } h_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_IF_LAST,
        SEQ_IF_NO_TAIL,
        SEQ_GOTO
    } seq_t;

    typedef enum logic [1:0] {
        DISP_STAY,
        DISP_MIX,
        DISP_TAIL,
        DISP_FIN
    } disp_t;

    typedef struct packed {
        logic     idle;
        mul_sel_t mul_sel;
        k_op_t    k_op;
        h_op_t    h_op;
        seq_t     seq;
        step_t    target;
        logic     emit;
    } ctrl_t;

    typedef struct packed {
        disp_t dispatch;
        logic  last;
        logic  tail_empty;
    } status_t;

    function automatic ctrl_t ucode(input step_t step);
        ctrl_t c;
        begin
            c.idle    = 1'b0;
            c.mul_sel = MUL_NONE;
            c.k_op    = K_NONE;
            c.h_op    = H_NONE;
            c.seq     = SEQ_NEXT;
            c.target  = STEP_IDLE;
            c.emit    = 1'b0;
            case (step)
                STEP_IDLE: begin
                    c.idle = 1'b1;
                    c.seq  = SEQ_GOTO;
                end
                STEP_MIX1: c.mul_sel = MUL_K;
                STEP_MIX2: c.k_op = K_P_XS24;
                STEP_MIX3: c.mul_sel = MUL_K;
                STEP_MIX4: begin
                    c.k_op    = K_LOAD_P;
                    c.mul_sel = MUL_H;
                end
                STEP_MIX5: begin
                    c.h_op   = H_P_XOR_K;
                    c.seq    = SEQ_IF_LAST;
                    c.target = STEP_TAIL1;
                end
                STEP_TAIL1: begin
                    c.h_op   = H_XOR_GATHER;
                    c.seq    = SEQ_IF_NO_TAIL;
                    c.target = STEP_FIN1;
                end
                STEP_TAIL2: c.mul_sel = MUL_H;
                STEP_TAIL3: c.h_op = H_LOAD_P;
                STEP_FIN1: c.h_op = H_XS13;
                STEP_FIN2: c.mul_sel = MUL_H;
                STEP_FIN3: begin
                    c.h_op   = H_P_XS15;
                    c.seq    = SEQ_GOTO;
                    c.target = STEP_IDLE;
                    c.emit   = 1'b1;
                end
                default: begin
                    c.seq    = SEQ_GOTO;
                    c.target = STEP_IDLE;
                end
            endcase
            return c;
        end
    endfunction

endpackage

### hw/rtl/mm2_sequencer.sv
`timescale 1ns / 1ps

module mm2_sequencer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_accept,
    input  logic            fire,
    input  mm2_pkg::status_t status,
    output mm2_pkg::ctrl_t  ctrl
);

    mm2_pkg::step_t step_reg;
    mm2_pkg::step_t step_next;

    assign ctrl = mm2_pkg::ucode(step_reg);

    always_comb begin
        step_next = step_reg;
        if (ctrl.idle) begin
            if (in_accept) begin
                case (status.dispatch)
                    mm2_pkg::DISP_MIX:  step_next = mm2_pkg::STEP_MIX1;
                    mm2_pkg::DISP_TAIL: step_next = mm2_pkg::STEP_TAIL1;
                    mm2_pkg::DISP_FIN:  step_next = mm2_pkg::STEP_FIN1;
                    default:            step_next = mm2_pkg::STEP_IDLE;
                endcase
            end
        end else if (fire) begin
            case (ctrl.seq)
                mm2_pkg::SEQ_NEXT: step_next = step_reg + 4'd1;
                mm2_pkg::SEQ_IF_LAST: begin
                    step_next = status.last ? ctrl.target : mm2_pkg::STEP_IDLE;
                end
                mm2_pkg::SEQ_IF_NO_TAIL: begin
                    step_next = status.tail_empty ? ctrl.target : step_reg + 4'd1;
                end
                mm2_pkg::SEQ_GOTO: step_next = ctrl.target;
                default: step_next = mm2_pkg::STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= mm2_pkg::STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

### hw/rtl/mm2_datapath.sv
`timescale 1ns / 1ps

module mm2_datapath #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_accept,
    input  logic                    fire,
    input  mm2_pkg::ctrl_t          ctrl,
    input  logic [31:0]             hash_seed,
    input  logic [7:0]              key_byte,
    input  logic [LENGTH_WIDTH-1:0] message_length,
    input  logic                    first_byte,
    input  logic                    last_byte,
    input  logic                    empty_message,
    output mm2_pkg::status_t        status,
    output logic [31:0]             fin_value
);

    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] p_reg, p_next;
    logic [23:0] gather_reg, gather_next;
    logic [1:0]  pos_reg, pos_next;
    logic        last_reg, last_next;

    logic [1:0]  eff_pos;
    logic [23:0] eff_gather;
    logic [23:0] gather_ins;
    logic [31:0] h_base;
    logic [31:0] mul_in;

    assign eff_pos    = first_byte ? 2'd0 : pos_reg;
    assign eff_gather = first_byte ? 24'd0 : gather_reg;
    assign h_base     = first_byte ? (hash_seed ^ 32'(message_length)) : h_reg;
    assign fin_value  = p_reg ^ (p_reg >> mm2_pkg::FIN_SHIFT_B);

    always_comb begin
        case (eff_pos)
            2'd0:    gather_ins = {16'd0, key_byte};
            2'd1:    gather_ins = {8'd0, key_byte, 8'd0};
            default: gather_ins = {key_byte, 16'd0};
        endcase
    end

    always_comb begin
        if (empty_message) begin
            status.dispatch = mm2_pkg::DISP_FIN;
        end else if (eff_pos == 2'd3) begin
            status.dispatch = mm2_pkg::DISP_MIX;
        end else if (last_byte) begin
            status.dispatch = mm2_pkg::DISP_TAIL;
        end else begin
            status.dispatch = mm2_pkg::DISP_STAY;
        end
        status.last       = last_reg;
        status.tail_empty = (pos_reg == 2'd0);
    end

    always_comb begin
        case (ctrl.mul_sel)
            mm2_pkg::MUL_K: mul_in = k_reg;
            default:        mul_in = h_reg;
        endcase
    end

    always_comb begin
        h_next      = h_reg;
        k_next      = k_reg;
        p_next      = p_reg;
        gather_next = gather_reg;
        pos_next    = pos_reg;
        last_next   = last_reg;
        if (in_accept) begin
            last_next = last_byte;
            if (empty_message) begin
                h_next      = hash_seed;
                gather_next = 24'd0;
                pos_next    = 2'd0;
            end else if (eff_pos == 2'd3) begin
                h_next      = h_base;
                k_next      = {key_byte, eff_gather};
                gather_next = 24'd0;
                pos_next    = 2'd0;
            end else begin
                h_next      = h_base;
                gather_next = eff_gather | gather_ins;
                pos_next    = eff_pos + 2'd1;
            end
        end else if (fire && !ctrl.idle) begin
            if (ctrl.mul_sel != mm2_pkg::MUL_NONE) begin
                p_next = mul_in * mm2_pkg::MIX_MULT;
            end
            case (ctrl.k_op)
                mm2_pkg::K_LOAD_P: k_next = p_reg;
                mm2_pkg::K_P_XS24: k_next = p_reg ^ (p_reg >> mm2_pkg::WORD_SHIFT);
                default:           k_next = k_reg;
            endcase
            case (ctrl.h_op)
                mm2_pkg::H_LOAD_P:     h_next = p_reg;
                mm2_pkg::H_XOR_GATHER: h_next = h_reg ^ {8'd0, gather_reg};
                mm2_pkg::H_XS13:       h_next = h_reg ^ (h_reg >> mm2_pkg::FIN_SHIFT_A);
                mm2_pkg::H_P_XOR_K:    h_next = p_reg ^ k_reg;
                mm2_pkg::H_P_XS15:     h_next = fin_value;
                default:               h_next = h_reg;
            endcase
            if (ctrl.emit) begin
                gather_next = 24'd0;
                pos_next    = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg      <= 32'd0;
            gather_reg <= 24'd0;
            pos_reg    <= 2'd0;
            last_reg   <= 1'b0;
        end else begin
            h_reg      <= h_next;
            gather_reg <= gather_next;
            pos_reg    <= pos_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        p_reg <= p_next;
    end

endmodule

### hw/rtl/murmur2_hash_stream.sv
`timescale 1ns / 1ps

// Streaming 32-bit MurmurHash2 engine, one message byte per input word.
// The input channel (s_*) carries a byte with first, last and empty-message
// flags; the length is sampled on the first word and seeds the hash with
// the seed register, which is written through cfg_wr_en and cfg_wr_data.
// The result channel (m_*) carries one hash per message, held in an output
// register until it is taken.
// A byte that does not complete a 32-bit word is gathered while the engine stays
// ready. A byte that completes a word starts a short microprogram that runs the
// three mix multiplies through one registered multiplier. The last byte adds the
// tail and finalization steps, and an empty-message word runs only the
// finalization steps; s_ready is low while a microprogram runs.
// A new word is accepted while an earlier hash still waits in the output
// register; if the receiver stalls, the sequencer holds at its final step
// until the output register is free.
// Reset clears the running hash, the byte gather state and the output
// valid, and sets the seed to 97.

module murmur2_hash_stream #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [31:0]             cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_key_byte,
    input  logic [LENGTH_WIDTH-1:0] s_message_length,
    input  logic                    s_first_byte,
    input  logic                    s_last_byte,
    input  logic                    s_empty_message,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [31:0]             m_hash_value
);

    logic [31:0]      hash_seed_reg;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_hash_value_reg;
    logic             in_accept;
    logic             out_full;
    logic             fire;
    mm2_pkg::ctrl_t   ctrl;
    mm2_pkg::status_t status;
    logic [31:0]      fin_value;

    assign s_ready      = ctrl.idle;
    assign in_accept    = s_valid && s_ready;
    assign out_full     = m_valid_reg && !m_ready;
    assign fire         = !(ctrl.emit && out_full);
    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_value_reg;

    mm2_sequencer u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .fire      (fire),
        .status    (status),
        .ctrl      (ctrl)
    );

    mm2_datapath #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_accept      (in_accept),
        .fire           (fire),
        .ctrl           (ctrl),
        .hash_seed      (hash_seed_reg),
        .key_byte       (s_key_byte),
        .message_length (s_message_length),
        .first_byte     (s_first_byte),
        .last_byte      (s_last_byte),
        .empty_message  (s_empty_message),
        .status         (status),
        .fin_value      (fin_value)
    );

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (ctrl.emit && fire) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_seed_reg <= mm2_pkg::SEED_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                hash_seed_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit && fire) begin
            m_hash_value_reg <= fin_value;
        end
    end

    // An empty-message word always starts the finalization program.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_empty_message |=> !s_ready)
        else $error("empty message did not start finalization");

    // A new hash only appears from the final microprogram step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(ctrl.emit))
        else $error("result raised outside the final step");

    // A stalled receiver holds the sequencer at its final step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit && m_valid && !m_ready |=> ctrl.emit && m_valid)
        else $error("final step left while the output was full");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int LEN_W            = 16;
    localparam int SETTLE_CYCLES    = 24;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int SHOWN_MISMATCHES = 10;

    typedef struct {
        logic [7:0]       key;
        logic [LEN_W-1:0] len;
        logic             first;
        logic             last;
        logic             empty;
    } key_word_t;

    logic             aclk             = 1'b0;
    logic             aresetn          = 1'b0;
    logic             cfg_wr_en        = 1'b0;
    logic [31:0]      cfg_wr_data      = '0;
    logic             s_valid          = 1'b0;
    logic             s_ready;
    logic [7:0]       s_key_byte       = '0;
    logic [LEN_W-1:0] s_message_length = '0;
    logic             s_first_byte     = 1'b0;
    logic             s_last_byte      = 1'b0;
    logic             s_empty_message  = 1'b0;
    logic             m_valid;
    logic             m_ready          = 1'b0;
    logic [31:0]      m_hash_value;

    key_word_t   pending_words[$];
    logic [31:0] expected_hashes[$];

    logic [31:0] model_seed   = mm2_pkg::SEED_RESET;
    logic [31:0] model_hash   = '0;
    logic [23:0] model_gather = '0;
    logic [1:0]  model_count  = '0;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int words_queued   = 0;
    int words_accepted = 0;
    int hashes_checked = 0;
    int errors         = 0;
    int stall_cycles   = 0;

    murmur2_hash_stream #(
        .LENGTH_WIDTH(LEN_W)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key_byte      (s_key_byte),
        .s_message_length(s_message_length),
        .s_first_byte    (s_first_byte),
        .s_last_byte     (s_last_byte),
        .s_empty_message (s_empty_message),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hash_value    (m_hash_value)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [31:0] fold_word(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] km;
        km = k * mm2_pkg::MIX_MULT;
        km = km ^ (km >> mm2_pkg::WORD_SHIFT);
        km = km * mm2_pkg::MIX_MULT;
        return (h * mm2_pkg::MIX_MULT) ^ km;
    endfunction

    function automatic logic [31:0] finish_hash(input logic [31:0] h);
        logic [31:0] f;
        f = h ^ (h >> mm2_pkg::FIN_SHIFT_A);
        f = f * mm2_pkg::MIX_MULT;
        return f ^ (f >> mm2_pkg::FIN_SHIFT_B);
    endfunction

    task automatic predict_hash(input key_word_t w);
        if (w.empty) begin
            model_hash   = finish_hash(model_seed);
            model_gather = '0;
            model_count  = '0;
            expected_hashes = {expected_hashes, model_hash};
        end else begin
            if (w.first) begin
                model_hash   = model_seed ^ 32'(w.len);
                model_gather = '0;
                model_count  = '0;
            end
            if (model_count == 2'd3) begin
                model_hash   = fold_word(model_hash, {w.key, model_gather});
                model_gather = '0;
                model_count  = '0;
            end else begin
                model_gather = model_gather | (24'(w.key) << (8 * model_count));
                model_count  = model_count + 2'd1;
            end
            if (w.last) begin
                if (model_count != 2'd0) begin
                    model_hash = (model_hash ^ 32'(model_gather)) * mm2_pkg::MIX_MULT;
                end
                model_hash   = finish_hash(model_hash);
                model_gather = '0;
                model_count  = '0;
                expected_hashes = {expected_hashes, model_hash};
            end
        end
    endtask

    task automatic push_word(input logic [7:0] key, input logic [LEN_W-1:0] len,
                             input logic first, input logic last, input logic empty);
        key_word_t w;
        w.key   = key;
        w.len   = len;
        w.first = first;
        w.last  = last;
        w.empty = empty;
        pending_words = {pending_words, w};
        words_queued++;
    endtask

    task automatic push_message(input int n, input logic [LEN_W-1:0] len, input logic closed);
        for (int i = 0; i < n; i++) begin
            push_word(8'($urandom_range(0, 255)), len, i == 0, closed && (i == n - 1), 1'b0);
        end
    endtask

    // Mostly well-formed messages with random content; the rest are empty messages,
    // stray words with random flags, and messages cut off before their last byte.
    task automatic add_random_traffic(input int target);
        int added;
        int pick;
        int n;
        logic [LEN_W-1:0] len;
        added = 0;
        while (added < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                push_word(8'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 65535)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
                added++;
            end else if (pick < 14) begin
                push_word(8'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 65535)),
                          $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, 1'b0);
                added++;
            end else begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 48)
                                                 : $urandom_range(1, 9);
                len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 65535))
                                                  : LEN_W'(n);
                push_message(n, len, $urandom_range(0, 19) != 0);
                added += n;
            end
        end
    endtask

    task automatic drain_all();
        while (words_accepted != words_queued || expected_hashes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_seed(input logic [31:0] seed);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= seed;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        model_seed  = seed;
    endtask

    always @(posedge aclk) begin
        key_word_t cur;
        key_word_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cur = '{s_key_byte, s_message_length, s_first_byte, s_last_byte,
                        s_empty_message};
                predict_hash(cur);
                words_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_words.pop_front();
                    s_valid          <= 1'b1;
                    s_key_byte       <= nxt.key;
                    s_message_length <= nxt.len;
                    s_first_byte     <= nxt.first;
                    s_last_byte      <= nxt.last;
                    s_empty_message  <= nxt.empty;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_hashes.size() == 0) begin
                if (errors < SHOWN_MISMATCHES) begin
                    $display("Hash %08h arrived with none expected.", m_hash_value);
                end
                errors++;
            end else begin
                want = expected_hashes.pop_front();
                hashes_checked++;
                if (m_hash_value !== want) begin
                    if (errors < SHOWN_MISMATCHES) begin
                        $display("Hash mismatch: expected %08h, got %08h.", want, m_hash_value);
                    end
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Nothing moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [31:0] mid_seed;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 75;
        push_word(8'h3C, 16'd0, 1'b0, 1'b0, 1'b0);
        push_word(8'hC3, 16'd0, 1'b0, 1'b1, 1'b0);
        push_word(8'hFF, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        push_word(8'h00, 16'd0, 1'b1, 1'b1, 1'b1);
        push_word(8'hFF, 16'd1, 1'b1, 1'b1, 1'b0);
        push_word(8'h00, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        push_word(8'hA5, 16'hFFFF, 1'b0, 1'b1, 1'b0);
        push_word(8'hFF, 16'd4, 1'b1, 1'b0, 1'b0);
        push_word(8'h00, 16'd4, 1'b0, 1'b0, 1'b0);
        push_word(8'h80, 16'd4, 1'b0, 1'b0, 1'b0);
        push_word(8'h01, 16'd4, 1'b0, 1'b1, 1'b0);
        push_message(5, 16'd3, 1'b1);
        push_word(8'h55, 16'd0, 1'b0, 1'b0, 1'b0);
        push_word(8'hAA, 16'd0, 1'b0, 1'b0, 1'b0);
        push_word(8'h7F, 16'd0, 1'b0, 1'b1, 1'b0);
        push_word(8'h12, 16'd9, 1'b1, 1'b0, 1'b0);
        push_word(8'h34, 16'd9, 1'b0, 1'b0, 1'b0);
        push_word(8'h56, 16'd9, 1'b0, 1'b0, 1'b1);
        drain_all();

        load_seed(32'h0000_0000);
        add_random_traffic(130);
        drain_all();

        send_idle_pct = 75;
        recv_idle_pct = 18;
        load_seed(32'hFFFF_FFFF);
        add_random_traffic(130);
        drain_all();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        mid_seed = $urandom;
        load_seed(mid_seed);
        add_random_traffic(140);
        drain_all();

        if (expected_hashes.size() != 0) begin
            $display("%0d expected hashes never arrived.", expected_hashes.size());
            errors += expected_hashes.size();
        end
        $display("Sent %0d bytes and checked %0d hashes under seeds 97, 0, ffffffff and %08h.",
                 words_accepted, hashes_checked, mid_seed);
        $display("Traffic ran with sender gaps, receiver stalls, and back-to-back words.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches in total.", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
